FILE: rtl/hpop_pkg.sv
// hpop_pkg: types and constants of the HTTP POST object-id parser.
// No dependencies; imported by hpop_step and http_post_oid_parser.
package hpop_pkg;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_PLAY   = 3'd1,
        EV_REPLY  = 3'd2,
        EV_PREFIX = 3'd3,
        EV_BADNUM = 3'd4
    } t_event;

    // Parse phase: prefix characters, digit gathering, blank-line bytes
    typedef enum logic [3:0] {
        PH_PFX0   = 4'd0,
        PH_PFX1   = 4'd1,
        PH_PFX2   = 4'd2,
        PH_PFX3   = 4'd3,
        PH_PFX4   = 4'd4,
        PH_PFX5   = 4'd5,
        PH_DIGITS = 4'd6,
        PH_BLANK0 = 4'd7,
        PH_BLANK1 = 4'd8,
        PH_BLANK2 = 4'd9,
        PH_BLANK3 = 4'd10
    } t_phase;

    localparam int          PREFIX_LEN = 6;
    localparam int          BLANK_LEN  = 4;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_NINE    = 8'h39;

    // "POST /"
    localparam logic [7:0] PREFIX_LIT [PREFIX_LEN] =
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h2F};
    // CR LF CR LF
    localparam logic [7:0] BLANK_LIT [BLANK_LEN] =
        '{8'h0D, 8'h0A, 8'h0D, 8'h0A};

endpackage

FILE: rtl/hpop_step.sv
// hpop_step: per-byte parse rule, purely combinational.
// Depends on hpop_pkg.
module hpop_step #(
    parameter int ID_WIDTH = 16
) (
    input  logic [7:0]          i_byte,
    input  hpop_pkg::t_phase    i_phase,
    input  logic [ID_WIDTH-1:0] i_acc,
    output hpop_pkg::t_phase    o_phase,
    output logic [ID_WIDTH-1:0] o_acc,
    output hpop_pkg::t_event    o_event,
    output logic [ID_WIDTH-1:0] o_oid
);
    import hpop_pkg::*;

    t_phase              w_ph;
    t_phase              w_ph_in;
    logic [1:0]          w_blank_off;
    logic [3:0]          w_digit;
    logic [ID_WIDTH+3:0] w_prod;
    logic                w_is_digit;

    // acc * 10 + digit, four guard bits for saturation
    assign w_digit    = 4'(i_byte - CH_ZERO);
    assign w_is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_prod     = ({4'b0, i_acc} << 3) + ({4'b0, i_acc} << 1)
                      + {{ID_WIDTH{1'b0}}, w_digit};

    // unreachable phases fold onto the first blank-line phase
    assign w_ph_in = (i_phase > PH_BLANK3) ? PH_BLANK0 : i_phase;

    always_comb begin
        w_ph        = w_ph_in;
        o_acc       = i_acc;
        o_event     = EV_NONE;
        o_oid       = '0;
        w_blank_off = 2'd0;

        if (w_ph < PH_DIGITS) begin
            if (i_byte == PREFIX_LIT[w_ph[2:0]]) begin
                w_ph = t_phase'(w_ph + 4'd1);
            end else begin
                o_event = EV_PREFIX;
                w_ph    = PH_BLANK0;
            end
        end else if (w_ph == PH_DIGITS) begin
            if (w_is_digit) begin
                o_acc = (|w_prod[ID_WIDTH+3:ID_WIDTH]) ? '1 : w_prod[ID_WIDTH-1:0];
            end else if (i_byte == CH_SPACE) begin
                o_event = EV_PLAY;
                o_oid   = i_acc;
                o_acc   = '0;
                w_ph    = PH_BLANK0;
            end else begin
                o_event = EV_BADNUM;
                o_acc   = '0;
                w_ph    = PH_BLANK0;
            end
        end

        // same byte is checked against the blank line once past the number
        if (w_ph >= PH_BLANK0) begin
            w_blank_off = 2'(w_ph - PH_BLANK0);
            if (i_byte == BLANK_LIT[w_blank_off]) begin
                if (w_ph == PH_BLANK3) begin
                    o_event = EV_REPLY;
                    w_ph    = PH_PFX0;
                end else begin
                    w_ph = t_phase'(w_ph + 4'd1);
                end
            end else begin
                w_ph = PH_BLANK0;
            end
        end

        o_phase = w_ph;
    end

endmodule

FILE: rtl/http_post_oid_parser.sv
// http_post_oid_parser: top level, input register, parse state, result register.
// Depends on hpop_pkg and hpop_step.
//
// Byte-serial parser for "POST /<decimal> ... CR LF CR LF".
// Receive channel: i_rx_valid / o_rx_ready carry one byte (i_rx_byte) per
// transfer. Result channel: o_res_valid / i_res_ready carry exactly one result
// per byte: o_event_res (none, play, reply, prefix mismatch, invalid number)
// and o_object_id, which holds the parsed number on a play event and zero
// otherwise.
// Path: a byte taken passes the input register, then the result
// register, before it shows on the result channel.
// Throughput: one byte per cycle while results are taken; the parse
// rule is a single combinational step between the two registers.
// Stall: while a result waits, the byte held in the input register stays
// there; o_rx_ready drops only when both registers are full and the
// receiver is not taking the result.
// Reset (synchronous, active low): both registers empty, phase back to the
// first prefix character, accumulator cleared.
module http_post_oid_parser #(
    parameter int ID_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [2:0]          o_event_res,
    output logic [ID_WIDTH-1:0] o_object_id
);
    import hpop_pkg::*;

    // input register
    logic                r_s1_valid;
    logic [7:0]          r_s1_byte;

    // parse state
    t_phase              r_phase;
    logic [ID_WIDTH-1:0] r_acc;

    // result register
    logic                r_o_valid;
    t_event              r_o_event;
    logic [ID_WIDTH-1:0] r_o_oid;

    t_phase              n_phase;
    logic [ID_WIDTH-1:0] n_acc;
    t_event              w_event;
    logic [ID_WIDTH-1:0] w_oid;

    logic                w_out_free;
    logic                w_s1_move;

    // result register free, or emptying this cycle
    assign w_out_free = !r_o_valid || i_res_ready;
    // byte in the input register is parsed and its result registered
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_rx_ready = !r_s1_valid || w_out_free;

    hpop_step #(
        .ID_WIDTH (ID_WIDTH)
    ) u_step (
        .i_byte  (r_s1_byte),
        .i_phase (r_phase),
        .i_acc   (r_acc),
        .o_phase (n_phase),
        .o_acc   (n_acc),
        .o_event (w_event),
        .o_oid   (w_oid)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_s1_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_s1_byte <= i_rx_byte;
        end
    end

    // parse state advances once per parsed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PFX0;
            r_acc   <= '0;
        end else if (w_s1_move) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_o_event <= w_event;
            r_o_oid   <= w_oid;
        end
    end

    assign o_res_valid = r_o_valid;
    assign o_event_res = r_o_event;
    assign o_object_id = r_o_oid;

`ifndef ASSERT_OFF
    // accumulator is only ever non-zero while digits are being gathered
    a_acc_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_DIGITS |-> r_acc == '0)
        else $error("accumulator non-zero outside digit phase");

    // object id is zero on every event other than play
    a_oid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_event != EV_PLAY) |-> r_o_oid == '0)
        else $error("object id set on non-play event");

    // a reply restarts parsing at the prefix
    a_reply_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_move && w_event == EV_REPLY) |=> r_phase == PH_PFX0)
        else $error("reply did not restart prefix match");

    // back-pressure only when both registers are full and the result stalls
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (r_s1_valid && r_o_valid && !i_res_ready))
        else $error("receive ready dropped without a stall");
`endif

endmodule
